@@ design/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and constants for the greedy cone matcher.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_OBJECTS_DEF = 64;
  localparam int ANGLE_BITS_DEF  = 12;
  localparam int CONE_W          = 26;
  localparam logic [CONE_W-1:0] CONE_RESET = 26'd38265;
  localparam int INDEX_W         = 6;
  localparam int KIND_W          = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

endpackage

@@ design/gcm_cell.sv @@
// ----------------------------------------------------------------------------
// gcm_cell
// One table entry; rotates toward its neighbor while a query scans.
// ----------------------------------------------------------------------------
module gcm_cell #(
  parameter int ANGLE_BITS = gcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic                         load,
  input  logic signed [ANGLE_BITS:0]   load_eta,
  input  logic [ANGLE_BITS-1:0]        load_phi,
  input  logic signed [ANGLE_BITS:0]   next_eta,
  input  logic [ANGLE_BITS-1:0]        next_phi,
  output logic signed [ANGLE_BITS:0]   eta,
  output logic [ANGLE_BITS-1:0]        phi
);

  always_ff @(posedge clk) begin
    if (shift) begin
      eta <= next_eta;
      phi <= next_phi;
    end else if (load) begin
      eta <= load_eta;
      phi <= load_phi;
    end
  end

endmodule

@@ design/gcm_dist.sv @@
// ----------------------------------------------------------------------------
// gcm_dist
// Two-stage squared eta-phi distance unit at the head of the cell row.
// ----------------------------------------------------------------------------
module gcm_dist #(
  parameter int ANGLE_BITS = gcm_pkg::ANGLE_BITS_DEF,
  parameter int IW         = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IW-1:0]                in_idx,
  input  logic signed [ANGLE_BITS:0]   gen_eta,
  input  logic [ANGLE_BITS-1:0]        gen_phi,
  input  logic signed [ANGLE_BITS:0]   obj_eta,
  input  logic [ANGLE_BITS-1:0]        obj_phi,
  output logic                         out_valid,
  output logic [IW-1:0]                out_idx,
  output logic [2*ANGLE_BITS+2:0]      out_dist
);

  localparam int A = ANGLE_BITS;
  localparam logic [A-1:0] HALF = A'(1) << (A - 1);

  logic signed [A+1:0] de;
  logic [A:0]          ade;
  logic [A-1:0]        dp_raw;
  logic [A-1:0]        dp;

  logic                v1;
  logic [IW-1:0]       idx1;
  logic [A:0]          ade1;
  logic [A-1:0]        dp1;
  logic [2*A+1:0]      sqe;
  logic [2*A-1:0]      sqp;
  logic                v2;
  logic [IW-1:0]       idx2;

  always_comb begin
    de     = (A+2)'(gen_eta) - (A+2)'(obj_eta);
    ade    = de[A+1] ? (A+1)'(-de) : de[A:0];
    dp_raw = gen_phi - obj_phi;
    // fold to the short way around the circle
    dp     = (dp_raw > HALF) ? (A'(0) - dp_raw) : dp_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    idx1 <= in_idx;
    ade1 <= ade;
    dp1  <= dp;
    idx2 <= idx1;
    sqe  <= ade1 * ade1;
    sqp  <= dp1 * dp1;
  end

  assign out_valid = v2;
  assign out_idx   = idx2;
  assign out_dist  = (2*A+3)'(sqe) + (2*A+3)'(sqp);

endmodule

@@ design/greedy_cone_matcher_top.sv @@
// ----------------------------------------------------------------------------
// greedy_cone_matcher_top
// Greedy nearest-neighbour matcher in eta-phi space over a table of objects.
// ----------------------------------------------------------------------------
// Usage: words enter on the s_ channel. tuser carries the kind (clear, load,
// query); tdata carries eta, phi and the query flag. Clear and load words give
// no result. A query gives one result word on the m_ channel: matched flag and
// index of the nearest unused object within the cone, which is then marked
// used. A query rotates the cell row once past a single distance unit, one
// entry per cycle; an invalid query goes straight to its result with no scan.
// One item is in work at a time.
// cfg_we writes the squared cone radius; write only while idle.
// Reset empties the table, clears the used marks and restores the default
// cone. When the receiver stalls, the result is held in the output register
// and new clear or load words are still taken; a following query waits
// until the held result has been taken.
// ----------------------------------------------------------------------------
module greedy_cone_matcher_top #(
  parameter int MAX_OBJECTS = gcm_pkg::MAX_OBJECTS_DEF,
  parameter int ANGLE_BITS  = gcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // eta, phi, query_valid
  input  logic [((2*ANGLE_BITS+2+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [gcm_pkg::KIND_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // matched, match_index
  output logic [7:0]                         m_tdata,
  input  logic                               cfg_we,
  input  logic [gcm_pkg::CONE_W-1:0]         cfg_wdata
);

  localparam int A    = ANGLE_BITS;
  localparam int IW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNTW = $clog2(MAX_OBJECTS + 1);
  localparam int SCW  = $clog2(MAX_OBJECTS + 3);
  localparam int DW   = 2*A + 3;
  localparam int CW   = (DW > gcm_pkg::CONE_W) ? DW : gcm_pkg::CONE_W;

  gcm_pkg::state_t state, state_next;

  logic [gcm_pkg::CONE_W-1:0] cone;
  logic [CNTW-1:0]            count;
  logic [MAX_OBJECTS-1:0]     used;
  logic [SCW-1:0]             scan_cnt;
  logic signed [A:0]          gen_eta;
  logic [A-1:0]               gen_phi;
  logic                       found;
  logic [IW-1:0]              best_idx;
  logic [DW-1:0]              best_d;
  logic                       res_valid;
  logic                       res_matched;
  logic [gcm_pkg::INDEX_W-1:0] res_index;

  logic signed [A:0] in_eta;
  logic [A-1:0]      in_phi;
  logic              in_qv;
  logic              accept;
  logic              issue;
  logic [IW-1:0]     scan_idx;
  logic              entry_live;

  logic signed [A:0] cell_eta [MAX_OBJECTS];
  logic [A-1:0]      cell_phi [MAX_OBJECTS];

  logic              d_valid;
  logic [IW-1:0]     d_idx;
  logic [DW-1:0]     d_dist;
  logic              hit;

  assign in_eta   = s_tdata[A:0];
  assign in_phi   = s_tdata[2*A:A+1];
  assign in_qv    = s_tdata[2*A+1];
  assign s_tready = (state == gcm_pkg::ST_IDLE) &&
                    !(s_tuser == gcm_pkg::KIND_QUERY && res_valid);
  assign accept   = s_tvalid && s_tready;
  assign scan_idx = scan_cnt[IW-1:0];
  assign issue    = (state == gcm_pkg::ST_SCAN) && (scan_cnt < SCW'(MAX_OBJECTS));
  assign entry_live = issue && (CNTW'(scan_idx) < count) && !used[scan_idx];
  assign hit = found && (CW'(best_d) <= CW'(cone));

  // row of cells, rotating toward cell 0
  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
    gcm_cell #(.ANGLE_BITS(A)) u_cell (
      .clk      (clk),
      .shift    (issue),
      .load     (accept && s_tuser == gcm_pkg::KIND_LOAD && count == CNTW'(i)),
      .load_eta (in_eta),
      .load_phi (in_phi),
      .next_eta (cell_eta[(i + 1) % MAX_OBJECTS]),
      .next_phi (cell_phi[(i + 1) % MAX_OBJECTS]),
      .eta      (cell_eta[i]),
      .phi      (cell_phi[i])
    );
  end

  gcm_dist #(.ANGLE_BITS(A), .IW(IW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (entry_live),
    .in_idx    (scan_idx),
    .gen_eta   (gen_eta),
    .gen_phi   (gen_phi),
    .obj_eta   (cell_eta[0]),
    .obj_phi   (cell_phi[0]),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_dist  (d_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gcm_pkg::ST_IDLE: begin
        if (accept && s_tuser == gcm_pkg::KIND_QUERY) begin
          state_next = in_qv ? gcm_pkg::ST_SCAN : gcm_pkg::ST_FINISH;
        end
      end
      gcm_pkg::ST_SCAN: begin
        if (scan_cnt == SCW'(MAX_OBJECTS + 2)) begin
          state_next = gcm_pkg::ST_FINISH;
        end
      end
      gcm_pkg::ST_FINISH: begin
        state_next = gcm_pkg::ST_IDLE;
      end
      default: state_next = gcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cone      <= gcm_pkg::CONE_RESET;
      count     <= '0;
      used      <= '0;
      scan_cnt  <= '0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cone <= cfg_wdata;
      end
      if (res_valid && m_tready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        case (s_tuser)
          gcm_pkg::KIND_CLEAR: begin
            count <= '0;
            used  <= '0;
          end
          gcm_pkg::KIND_LOAD: begin
            if (count < CNTW'(MAX_OBJECTS)) begin
              used[count[IW-1:0]] <= 1'b0;
              count <= count + CNTW'(1);
            end
          end
          gcm_pkg::KIND_QUERY: begin
            scan_cnt <= '0;
            found    <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == gcm_pkg::ST_SCAN) begin
        scan_cnt <= scan_cnt + SCW'(1);
      end
      // strict less-than keeps the first index on a tie
      if (d_valid && (!found || d_dist < best_d)) begin
        found <= 1'b1;
      end
      if (state == gcm_pkg::ST_FINISH) begin
        res_valid <= 1'b1;
        if (hit) begin
          used[best_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == gcm_pkg::KIND_QUERY) begin
      gen_eta <= in_eta;
      gen_phi <= in_phi;
    end
    if (d_valid && (!found || d_dist < best_d)) begin
      best_idx <= d_idx;
      best_d   <= d_dist;
    end
    if (state == gcm_pkg::ST_FINISH) begin
      res_matched <= hit;
      res_index   <= hit ? gcm_pkg::INDEX_W'(best_idx) : '0;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {1'b0, res_index, res_matched};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_OBJECTS))
    else $error("table count beyond capacity");
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == '0)
    else $error("index not zero on a miss");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == gcm_pkg::ST_SCAN |-> !s_tready)
    else $error("input taken during a scan");
  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    state == gcm_pkg::ST_FINISH |=> m_tvalid)
    else $error("finished query gave no result");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the greedy cone matcher against a built-in predictor: a directed
// table of clear, load and query words, then random table fills and queries
// under several cone settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NOBJ = gcm_pkg::MAX_OBJECTS_DEF;
  localparam int AB   = gcm_pkg::ANGLE_BITS_DEF;
  localparam int DW   = ((2*AB+2+7)/8)*8;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       matched;
    logic [5:0] index;
  } match_t;

  typedef struct {
    gcm_pkg::kind_t kind;
    logic [12:0]    eta;
    logic [11:0]    phi;
    logic           qv;
    logic           chk;
    match_t         want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic [gcm_pkg::KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;
  logic cfg_we = 0;
  logic [gcm_pkg::CONE_W-1:0] cfg_wdata = '0;

  greedy_cone_matcher_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [12:0] tbl_eta [NOBJ];
  logic [11:0] tbl_phi [NOBJ];
  logic tbl_used [NOBJ];
  int tbl_n;
  logic [gcm_pkg::CONE_W-1:0] cone_sq;

  match_t pending_matches[$];
  int errors = 0;
  int n_words = 0, n_results = 0, n_hits = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit calm = 0;

  function automatic logic [27:0] sep_sq(logic signed [12:0] ea, logic [11:0] pa,
                                         logic signed [12:0] eb, logic [11:0] pb);
    logic signed [14:0] de;
    logic [13:0] ade;
    logic [11:0] dp;
    logic [12:0] mp;
    de = ea - eb;
    ade = de < 0 ? -de : de;
    dp = pa - pb;
    mp = dp > 12'd2048 ? 13'd4096 - dp : dp;
    return 28'(ade) * 28'(ade) + 28'(mp) * 28'(mp);
  endfunction

  // applies one accepted word to the table and queues the expected match
  task automatic predict_match(gcm_pkg::kind_t k, logic [12:0] eta, logic [11:0] phi,
                               logic qv);
    int best;
    logic [27:0] best_d, d;
    match_t m;
    case (k)
      gcm_pkg::KIND_CLEAR: begin
        tbl_n = 0;
        foreach (tbl_used[i]) tbl_used[i] = 0;
      end
      gcm_pkg::KIND_LOAD: begin
        if (tbl_n < NOBJ) begin
          tbl_eta[tbl_n] = eta;
          tbl_phi[tbl_n] = phi;
          tbl_used[tbl_n] = 0;
          tbl_n++;
        end
      end
      gcm_pkg::KIND_QUERY: begin
        m = '0;
        best = -1;
        best_d = '0;
        if (qv) begin
          for (int j = 0; j < tbl_n; j++) begin
            if (!tbl_used[j]) begin
              d = sep_sq(eta, phi, tbl_eta[j], tbl_phi[j]);
              if (best < 0 || d < best_d) begin
                best = j;
                best_d = d;
              end
            end
          end
          if (best >= 0 && best_d <= 28'(cone_sq)) begin
            tbl_used[best] = 1;
            m.matched = 1;
            m.index = best[5:0];
          end
        end
        pending_matches = {pending_matches, m};
      end
      default: ;
    endcase
  endtask

  task automatic send_word(gcm_pkg::kind_t k, logic [12:0] eta, logic [11:0] phi,
                           logic qv);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tuser <= k;
    s_tdata <= DW'({qv, phi, eta});
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_match(k, eta, phi, qv);
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain_and_wait();
    s_tvalid <= 0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (NOBJ + 10) @(negedge clk);
  endtask

  task automatic write_cone(logic [gcm_pkg::CONE_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    cone_sq = v;
  endtask

  function automatic logic [12:0] rand_eta();
    case ($urandom_range(0, 5))
      0: return 13'h1000;
      1: return 13'h0FFF;
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  // receiver with random stall bursts
  initial begin
    int stall;
    @(negedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 0;
        stall = $urandom_range(1, 14);
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    match_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.matched = m_tdata[0];
      got.index = m_tdata[6:1];
      n_results++;
      if (got.matched) n_hits++;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (got.matched !== want.matched || got.index !== want.index ||
            m_tdata[7] !== 1'b0) begin
          $display("%0t: mismatch expected matched=%0d index=%0d got matched=%0d index=%0d",
                   $realtime, want.matched, want.index, got.matched, got.index);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted words of either channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      timed_out = 1;
    end
  end

  initial begin
    row_t dir [$];
    row_t r;
    match_t pred;
    int set_size;
    logic [12:0] e;
    logic [11:0] p;
    logic [gcm_pkg::CONE_W-1:0] cone_steps [4];

    tbl_n = 0;
    cone_sq = gcm_pkg::CONE_RESET;
    foreach (tbl_used[i]) tbl_used[i] = 0;

    // directed table: chk marks rows with a result read off by hand
    dir = '{
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b1, 1'b1, '{1'b0, 6'd0}},  // empty table
      '{gcm_pkg::KIND_LOAD,  13'h0000, 12'h000, 1'b0, 1'b0, '0},
      '{gcm_pkg::KIND_LOAD,  13'h0FFF, 12'hFFF, 1'b1, 1'b0, '0},
      '{gcm_pkg::KIND_LOAD,  13'h1000, 12'h800, 1'b1, 1'b0, '0},
      '{gcm_pkg::KIND_LOAD,  13'h0000, 12'h000, 1'b1, 1'b0, '0},  // duplicate of entry 0
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b0, 1'b1, '{1'b0, 6'd0}},  // invalid query
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b1, 1'b1, '{1'b1, 6'd0}},  // tie takes first
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b1, 1'b1, '{1'b1, 6'd3}},
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b1, 1'b1, '{1'b0, 6'd0}},  // out of cone
      '{gcm_pkg::KIND_QUERY, 13'h0FFF, 12'h001, 1'b1, 1'b1, '{1'b1, 6'd1}},  // phi wraps
      '{gcm_pkg::KIND_QUERY, 13'h1000, 12'h000, 1'b1, 1'b0, '0},  // half circle
      '{gcm_pkg::KIND_QUERY, 13'h1000, 12'h800, 1'b1, 1'b0, '0},
      row_t'{gcm_pkg::kind_t'(2'd3), 13'h1FFF, 12'hFFF, 1'b1, 1'b0, '0},  // unused kind
      '{gcm_pkg::KIND_CLEAR, 13'h1FFF, 12'hFFF, 1'b1, 1'b0, '0},
      '{gcm_pkg::KIND_QUERY, 13'h0000, 12'h000, 1'b1, 1'b1, '{1'b0, 6'd0}}   // after clear
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (dir[i]) begin
      r = dir[i];
      if (r.chk) begin
        // compare the predictor with the hand-read value, then roll it back
        predict_match(r.kind, r.eta, r.phi, r.qv);
        pred = pending_matches.pop_back();
        if (pred !== r.want) begin
          $display("%0t: directed row %0d expected matched=%0d index=%0d got predicted %p",
                   $realtime, i, r.want.matched, r.want.index, pred);
          errors++;
        end
        // send_word redoes the prediction
        if (pred.matched) tbl_used[pred.index] = 0;
      end
      send_word(r.kind, r.eta, r.phi, r.qv);
    end

    // overfill: loads past capacity are dropped
    for (int j = 0; j < NOBJ + 3; j++)
      send_word(gcm_pkg::KIND_LOAD, 13'(j * 40), 12'(j * 64), 1'b0);
    for (int j = 0; j < 4; j++)
      send_word(gcm_pkg::KIND_QUERY, 13'(j * 40 + 3), 12'(j * 64 + 2), 1'b1);
    drain_and_wait();

    cone_steps = '{26'd0, 26'h3FFFFFF, 26'd20000, 26'd400000};
    for (int ph = 0; ph < 4; ph++) begin
      write_cone(cone_steps[ph]);
      if (ph == 3) calm = 1;
      for (int s = 0; s < 3; s++) begin
        set_size = $urandom_range(0, 3) == 0 ? $urandom_range(20, NOBJ + 2)
                                             : $urandom_range(1, 10);
        send_word(gcm_pkg::KIND_CLEAR, 13'($urandom), 12'($urandom), 1'($urandom));
        for (int j = 0; j < set_size; j++)
          send_word(gcm_pkg::KIND_LOAD, rand_eta(), 12'($urandom), 1'($urandom));
        for (int j = 0; j < set_size + 2; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_word(gcm_pkg::kind_t'($urandom_range(0, 3)), 13'($urandom),
                      12'($urandom), 1'($urandom));
          end else begin
            // queries near a stored object most of the time
            if (tbl_n > 0 && $urandom_range(0, 3) != 0) begin
              int k;
              k = $urandom_range(0, tbl_n - 1);
              e = tbl_eta[k] + 13'($signed($urandom_range(0, 300)) - 150);
              p = tbl_phi[k] + 12'($signed($urandom_range(0, 300)) - 150);
            end else begin
              e = rand_eta();
              p = 12'($urandom);
            end
            send_word(gcm_pkg::KIND_QUERY, e, p, $urandom_range(0, 7) != 0);
          end
        end
      end
      drain_and_wait();
    end

    $display("covered %0d words, %0d results of which %0d matched, over four cone settings",
             n_words, n_results, n_hits);
    if (errors == 0 && pending_matches.size() == 0 && !timed_out)
      $display("greedy_cone_matcher_top test passed");
    else
      $display("greedy_cone_matcher_top test failed");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("timeout after %0d idle cycles", WATCHDOG);
    $display("greedy_cone_matcher_top test failed");
    $finish;
  end

endmodule
